@@ rtl/vwr_pkg.sv @@
// Shared types and constants for the vertex weld and remap block.
// Depends on nothing; every rtl file refers to it by scoped names.
package vwr_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int VWR_MAX_VERTICES = 1024;
    localparam int VWR_COORD_WIDTH  = 32;

    // Fixed field widths
    localparam int CMD_WIDTH    = 2;
    localparam int REF_WIDTH    = 10;
    localparam int INDEX_WIDTH  = 10;
    localparam int TOTAL_WIDTH  = 11;
    localparam int STATUS_WIDTH = 2;
    localparam int TOL_WIDTH    = 21;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 21'd11;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = 1;
    localparam int QCNT_WIDTH  = 2;

    // Command codes on the input channel
    localparam logic [CMD_WIDTH-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_REMAP = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_UNSEEN = 2'd2;

    // Classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_REMAP = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } vwr_op_t;

    typedef struct packed {
        vwr_op_t                op;
        logic [REF_WIDTH-1:0]   vref;
    } vwr_ctrl_t;

endpackage

@@ rtl/vertex_weld_remap.sv @@
// Top level of the vertex weld and remap block: tolerance register, front end and back end.
// Depends on vwr_pkg, vwr_front and vwr_back.
//
// Welds mesh vertices whose coordinates (signed Q12.20) lie strictly within the
// tolerance register on every axis, and remaps triangle indices to compact indices.
// Each input beat (cmd 0 add, 1 remap, 2 clear, 3 no-op) yields exactly one result
// beat. Input beats land in a two-deep queue, so up to two items can be taken while
// the back end works; the back end handles one item at a time. In the back end, an
// add scans the stored vertices in order and stops early when an earlier vertex
// matches; it reads one stored vertex per cycle from the single-read-port position
// store and compares it with the new one. A remap makes one store read; clear,
// no-op and rejected items go straight to the result. Results wait in an output
// register, so a stalled consumer holds that register and, once the next result is
// ready, also the back end, while the queue keeps filling. The stores need no
// clearing after reset: only entries below the vertex count are ever read.
// Write the tolerance only while the block is idle; it resets to 11 (about 1e-5).
module vertex_weld_remap #(
    parameter int MAX_VERTICES = vwr_pkg::VWR_MAX_VERTICES,
    parameter int COORD_WIDTH  = vwr_pkg::VWR_COORD_WIDTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [vwr_pkg::TOL_WIDTH-1:0]            cfg_wdata,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [vwr_pkg::CMD_WIDTH-1:0]            cmd,
    input  logic signed [COORD_WIDTH-1:0]            coord_x,
    input  logic signed [COORD_WIDTH-1:0]            coord_y,
    input  logic signed [COORD_WIDTH-1:0]            coord_z,
    input  logic [vwr_pkg::REF_WIDTH-1:0]            vertex_ref,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [vwr_pkg::STATUS_WIDTH-1:0]         status,
    output logic                                     is_unique,
    output logic [vwr_pkg::INDEX_WIDTH-1:0]          new_index,
    output logic signed [COORD_WIDTH-1:0]            out_x,
    output logic signed [COORD_WIDTH-1:0]            out_y,
    output logic signed [COORD_WIDTH-1:0]            out_z,
    output logic [vwr_pkg::TOTAL_WIDTH-1:0]          unique_total
);

    localparam int PW = 3 * COORD_WIDTH;

    logic [vwr_pkg::TOL_WIDTH-1:0]   tolerance_reg;
    logic                            item_valid;
    logic                            item_ready;
    vwr_pkg::vwr_ctrl_t              item_ctrl;
    logic [PW-1:0]                   item_pos;
    logic [PW-1:0]                   in_pos;
    logic [PW-1:0]                   out_pos;

    // Tolerance register: written on any cycle with the write enable high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= vwr_pkg::TOL_RESET;
        end
        else if (cfg_we)
        begin
            tolerance_reg <= cfg_wdata;
        end
    end

    // Pack the position as {z, y, x}
    assign in_pos = {coord_z, coord_y, coord_x};

    vwr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .in_pos     (in_pos),
        .vertex_ref (vertex_ref),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_ctrl  (item_ctrl),
        .item_pos   (item_pos)
    );

    vwr_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tolerance    (tolerance_reg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_ctrl    (item_ctrl),
        .item_pos     (item_pos),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .is_unique    (is_unique),
        .new_index    (new_index),
        .out_pos      (out_pos),
        .unique_total (unique_total)
    );

    // Unpack the echoed position
    assign out_x = out_pos[COORD_WIDTH-1:0];
    assign out_y = out_pos[2*COORD_WIDTH-1:COORD_WIDTH];
    assign out_z = out_pos[PW-1:2*COORD_WIDTH];

endmodule

@@ rtl/vwr_front.sv @@
// Front end: accepts input beats, classifies the command and queues the item.
// Depends on vwr_pkg.
module vwr_front #(
    parameter int COORD_WIDTH = vwr_pkg::VWR_COORD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [vwr_pkg::CMD_WIDTH-1:0]    cmd,
    input  logic [3*COORD_WIDTH-1:0]         in_pos,
    input  logic [vwr_pkg::REF_WIDTH-1:0]    vertex_ref,
    output logic                             item_valid,
    input  logic                             item_ready,
    output vwr_pkg::vwr_ctrl_t               item_ctrl,
    output logic [3*COORD_WIDTH-1:0]         item_pos
);

    localparam int PW = 3 * COORD_WIDTH;

    vwr_pkg::vwr_ctrl_t                   q_ctrl_reg [vwr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                        q_pos_reg  [vwr_pkg::QUEUE_DEPTH];
    logic [vwr_pkg::QPTR_WIDTH-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [vwr_pkg::QPTR_WIDTH-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [vwr_pkg::QCNT_WIDTH-1:0]       count_reg, count_next;
    logic                                 push, pop;
    vwr_pkg::vwr_ctrl_t                   ctrl_in;

    function automatic vwr_pkg::vwr_op_t classify(input logic [vwr_pkg::CMD_WIDTH-1:0] c);
        vwr_pkg::vwr_op_t op;
        case (c)
            vwr_pkg::CMD_ADD:   op = vwr_pkg::OP_ADD;
            vwr_pkg::CMD_REMAP: op = vwr_pkg::OP_REMAP;
            vwr_pkg::CMD_CLEAR: op = vwr_pkg::OP_CLEAR;
            default:            op = vwr_pkg::OP_NOP;
        endcase
        return op;
    endfunction

    assign in_ready   = (count_reg != vwr_pkg::QCNT_WIDTH'(vwr_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;
    assign item_ctrl  = q_ctrl_reg[rd_ptr_reg];
    assign item_pos   = q_pos_reg[rd_ptr_reg];

    always_comb
    begin
        ctrl_in.op   = classify(cmd);
        ctrl_in.vref = vertex_ref;
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots hold payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_ctrl_reg[wr_ptr_reg] <= ctrl_in;
            q_pos_reg[wr_ptr_reg]  <= in_pos;
        end
    end

endmodule

@@ rtl/vwr_back.sv @@
// Back end: scan sequencer, vertex and compact index stores, result register.
// Depends on vwr_pkg.
module vwr_back #(
    parameter int MAX_VERTICES = vwr_pkg::VWR_MAX_VERTICES,
    parameter int COORD_WIDTH  = vwr_pkg::VWR_COORD_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vwr_pkg::TOL_WIDTH-1:0]      tolerance,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  vwr_pkg::vwr_ctrl_t                 item_ctrl,
    input  logic [3*COORD_WIDTH-1:0]           item_pos,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [vwr_pkg::STATUS_WIDTH-1:0]   status,
    output logic                               is_unique,
    output logic [vwr_pkg::INDEX_WIDTH-1:0]    new_index,
    output logic [3*COORD_WIDTH-1:0]           out_pos,
    output logic [vwr_pkg::TOTAL_WIDTH-1:0]    unique_total
);

    localparam int PW   = 3 * COORD_WIDTH;
    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CNTW > vwr_pkg::REF_WIDTH) ? CNTW : vwr_pkg::REF_WIDTH;
    localparam int DW   = (COORD_WIDTH + 1 > vwr_pkg::TOL_WIDTH + 1) ?
                          COORD_WIDTH + 1 : vwr_pkg::TOL_WIDTH + 1;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_VERTICES);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_FIN  = 4'b1000
    } vwr_state_t;

    vwr_state_t                          state_reg, state_next;
    logic [CNTW-1:0]                     seen_reg, seen_next;
    logic [CNTW-1:0]                     uniq_reg, uniq_next;
    logic [CNTW-1:0]                     addr_reg, addr_next;
    logic                                rd_valid_reg, rd_valid_next;
    logic                                out_valid_reg, out_valid_next;

    logic [PW-1:0]                       pos_reg, pos_next;
    logic [vwr_pkg::STATUS_WIDTH-1:0]    res_status_reg, res_status_next;
    logic                                res_unique_reg, res_unique_next;
    logic [IDXW-1:0]                     res_idx_reg, res_idx_next;
    logic [vwr_pkg::STATUS_WIDTH-1:0]    out_status_reg, out_status_next;
    logic                                out_unique_reg, out_unique_next;
    logic [vwr_pkg::INDEX_WIDTH-1:0]     out_index_reg, out_index_next;
    logic [PW-1:0]                       out_pos_reg, out_pos_next;
    logic [vwr_pkg::TOTAL_WIDTH-1:0]     out_total_reg, out_total_next;

    logic [PW-1:0]                       pos_mem [MAX_VERTICES];
    logic [IDXW-1:0]                     idx_mem [MAX_VERTICES];
    logic [PW-1:0]                       pos_rd_reg;
    logic [IDXW-1:0]                     idx_rd_reg;

    logic                                mem_we;
    logic [IDXW-1:0]                     mem_widx;
    logic                                rd_pos_en, rd_idx_en;
    logic [IDXW-1:0]                     rd_addr;
    logic [2:0]                          axis_hit;
    logic                                scan_hit;
    logic                                take;

    function automatic logic axis_close(input logic signed [COORD_WIDTH-1:0] a,
                                        input logic signed [COORD_WIDTH-1:0] b,
                                        input logic [vwr_pkg::TOL_WIDTH-1:0] tol);
        logic signed [DW-1:0] diff;
        logic [DW-1:0]        mag;
        diff = DW'(a) - DW'(b);
        mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        return mag < DW'(tol);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            axis_hit[k] = axis_close(pos_reg[k*COORD_WIDTH +: COORD_WIDTH],
                                     pos_rd_reg[k*COORD_WIDTH +: COORD_WIDTH], tolerance);
        end
    end

    assign scan_hit   = rd_valid_reg && (&axis_hit);
    assign item_ready = (state_reg == ST_IDLE);
    assign take       = item_valid && item_ready;

    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        uniq_next       = uniq_reg;
        addr_next       = addr_reg;
        rd_valid_next   = rd_valid_reg;
        out_valid_next  = out_valid_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_unique_next = res_unique_reg;
        res_idx_next    = res_idx_reg;
        out_status_next = out_status_reg;
        out_unique_next = out_unique_reg;
        out_index_next  = out_index_reg;
        out_pos_next    = out_pos_reg;
        out_total_next  = out_total_reg;
        mem_we          = 1'b0;
        mem_widx        = idx_rd_reg;
        rd_pos_en       = 1'b0;
        rd_idx_en       = 1'b0;
        rd_addr         = addr_reg[IDXW-1:0];

        // Drop the held beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    pos_next        = item_pos;
                    res_status_next = vwr_pkg::STATUS_OK;
                    res_unique_next = 1'b0;
                    res_idx_next    = '0;
                    state_next      = ST_FIN;
                    case (item_ctrl.op)
                        vwr_pkg::OP_ADD:
                        begin
                            if (seen_reg == MAX_CNT)
                            begin
                                res_status_next = vwr_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                addr_next     = '0;
                                rd_valid_next = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        vwr_pkg::OP_REMAP:
                        begin
                            if (CMPW'(item_ctrl.vref) < CMPW'(seen_reg))
                            begin
                                rd_addr    = IDXW'(item_ctrl.vref);
                                rd_idx_en  = 1'b1;
                                state_next = ST_LOOK;
                            end
                            else
                            begin
                                res_status_next = vwr_pkg::STATUS_UNSEEN;
                            end
                        end
                        vwr_pkg::OP_CLEAR:
                        begin
                            seen_next = '0;
                            uniq_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    // First close match lends its compact index
                    res_idx_next  = idx_rd_reg;
                    mem_we        = 1'b1;
                    mem_widx      = idx_rd_reg;
                    seen_next     = seen_reg + 1'b1;
                    rd_valid_next = 1'b0;
                    state_next    = ST_FIN;
                end
                else if (!rd_valid_reg && (addr_reg == seen_reg))
                begin
                    res_idx_next    = IDXW'(uniq_reg);
                    res_unique_next = 1'b1;
                    uniq_next       = uniq_reg + 1'b1;
                    mem_we          = 1'b1;
                    mem_widx        = IDXW'(uniq_reg);
                    seen_next       = seen_reg + 1'b1;
                    state_next      = ST_FIN;
                end
                else if (addr_reg != seen_reg)
                begin
                    rd_pos_en     = 1'b1;
                    rd_idx_en     = 1'b1;
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
            end
            ST_LOOK:
            begin
                res_idx_next = idx_rd_reg;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_unique_next = res_unique_reg;
                    out_index_next  = vwr_pkg::INDEX_WIDTH'(res_idx_reg);
                    out_pos_next    = res_unique_reg ? pos_reg : '0;
                    out_total_next  = vwr_pkg::TOTAL_WIDTH'(uniq_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            uniq_reg      <= '0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            uniq_reg      <= uniq_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_unique_reg <= res_unique_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_unique_reg <= out_unique_next;
        out_index_reg  <= out_index_next;
        out_pos_reg    <= out_pos_next;
        out_total_reg  <= out_total_next;
    end

    // Position store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[seen_reg[IDXW-1:0]] <= pos_reg;
        end
        if (rd_pos_en)
        begin
            pos_rd_reg <= pos_mem[rd_addr];
        end
    end

    // Compact index store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            idx_mem[seen_reg[IDXW-1:0]] <= mem_widx;
        end
        if (rd_idx_en)
        begin
            idx_rd_reg <= idx_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign is_unique    = out_unique_reg;
    assign new_index    = out_index_reg;
    assign out_pos      = out_pos_reg;
    assign unique_total = out_total_reg;

`ifndef NO_ASSERTIONS
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= MAX_CNT)
        else $error("vertex count beyond store depth");

    a_uniq_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        uniq_reg <= seen_reg)
        else $error("more unique vertices than vertices seen");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (seen_reg < MAX_CNT))
        else $error("store written while full");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (item_ctrl.op == vwr_pkg::OP_CLEAR)) |=> (seen_reg == '0 && uniq_reg == '0))
        else $error("clear did not empty the store");
`endif

endmodule
